// ===== hw/rtl/skf_pkg.sv =====
// Shared types, constants and keymap tables of the scancode-to-character key FIFO.
`default_nettype none

package skf_pkg;

    // Character store geometry
    localparam int FIFO_DEPTH = 128;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CHAR_W     = 8;

    // Result queue in the back part
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_UP    = 2'd0,
        CFG_DOWN  = 2'd1,
        CFG_LEFT  = 2'd2,
        CFG_RIGHT = 2'd3
    } t_cfg_idx;

    localparam logic [CHAR_W-1:0] UP_RESET    = 8'd128;
    localparam logic [CHAR_W-1:0] DOWN_RESET  = 8'd129;
    localparam logic [CHAR_W-1:0] LEFT_RESET  = 8'd130;
    localparam logic [CHAR_W-1:0] RIGHT_RESET = 8'd131;

    // Set-1 scancodes
    localparam logic [7:0] SC_PREFIX   = 8'hE0;
    localparam logic [7:0] SC_REL_MASK = 8'h80;
    localparam logic [6:0] SC_LSHIFT   = 7'h2A;
    localparam logic [6:0] SC_RSHIFT   = 7'h36;
    localparam logic [6:0] SC_CAPS     = 7'h3A;
    localparam logic [6:0] SC_UP       = 7'h48;
    localparam logic [6:0] SC_DOWN     = 7'h50;
    localparam logic [6:0] SC_LEFT     = 7'h4B;
    localparam logic [6:0] SC_RIGHT    = 7'h4D;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_CASE    = 8'h20;

    // Command from the front part to the back part
    typedef struct packed {
        logic              is_read;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              char_valid;
        logic              key_waiting;
    } t_res;

    // US layout, no shift
    function automatic logic [7:0] plain_map(input logic [6:0] key);
        logic [7:0] c;
        unique case (key)
            7'd1:  c = 8'h1B;
            7'd2:  c = 8'h31;
            7'd3:  c = 8'h32;
            7'd4:  c = 8'h33;
            7'd5:  c = 8'h34;
            7'd6:  c = 8'h35;
            7'd7:  c = 8'h36;
            7'd8:  c = 8'h37;
            7'd9:  c = 8'h38;
            7'd10: c = 8'h39;
            7'd11: c = 8'h30;
            7'd12: c = 8'h2D;
            7'd13: c = 8'h3D;
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = 8'h71;
            7'd17: c = 8'h77;
            7'd18: c = 8'h65;
            7'd19: c = 8'h72;
            7'd20: c = 8'h74;
            7'd21: c = 8'h79;
            7'd22: c = 8'h75;
            7'd23: c = 8'h69;
            7'd24: c = 8'h6F;
            7'd25: c = 8'h70;
            7'd26: c = 8'h5B;
            7'd27: c = 8'h5D;
            7'd28: c = 8'h0A;
            7'd30: c = 8'h61;
            7'd31: c = 8'h73;
            7'd32: c = 8'h64;
            7'd33: c = 8'h66;
            7'd34: c = 8'h67;
            7'd35: c = 8'h68;
            7'd36: c = 8'h6A;
            7'd37: c = 8'h6B;
            7'd38: c = 8'h6C;
            7'd39: c = 8'h3B;
            7'd40: c = 8'h27;
            7'd41: c = 8'h60;
            7'd43: c = 8'h5C;
            7'd44: c = 8'h7A;
            7'd45: c = 8'h78;
            7'd46: c = 8'h63;
            7'd47: c = 8'h76;
            7'd48: c = 8'h62;
            7'd49: c = 8'h6E;
            7'd50: c = 8'h6D;
            7'd51: c = 8'h2C;
            7'd52: c = 8'h2E;
            7'd53: c = 8'h2F;
            7'd55: c = 8'h2A;
            7'd57: c = 8'h20;
            7'd74: c = 8'h2D;
            7'd78: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // US layout, shift held
    function automatic logic [7:0] upper_map(input logic [6:0] key);
        logic [7:0] c;
        unique case (key)
            7'd1:  c = 8'h1B;
            7'd2:  c = 8'h21;
            7'd3:  c = 8'h40;
            7'd4:  c = 8'h23;
            7'd5:  c = 8'h24;
            7'd6:  c = 8'h25;
            7'd7:  c = 8'h5E;
            7'd8:  c = 8'h26;
            7'd9:  c = 8'h2A;
            7'd10: c = 8'h28;
            7'd11: c = 8'h29;
            7'd12: c = 8'h5F;
            7'd13: c = 8'h2B;
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = 8'h51;
            7'd17: c = 8'h57;
            7'd18: c = 8'h45;
            7'd19: c = 8'h52;
            7'd20: c = 8'h54;
            7'd21: c = 8'h59;
            7'd22: c = 8'h55;
            7'd23: c = 8'h49;
            7'd24: c = 8'h4F;
            7'd25: c = 8'h50;
            7'd26: c = 8'h7B;
            7'd27: c = 8'h7D;
            7'd28: c = 8'h0A;
            7'd30: c = 8'h41;
            7'd31: c = 8'h53;
            7'd32: c = 8'h44;
            7'd33: c = 8'h46;
            7'd34: c = 8'h47;
            7'd35: c = 8'h48;
            7'd36: c = 8'h4A;
            7'd37: c = 8'h4B;
            7'd38: c = 8'h4C;
            7'd39: c = 8'h3A;
            7'd40: c = 8'h22;
            7'd41: c = 8'h7E;
            7'd43: c = 8'h7C;
            7'd44: c = 8'h5A;
            7'd45: c = 8'h58;
            7'd46: c = 8'h43;
            7'd47: c = 8'h56;
            7'd48: c = 8'h42;
            7'd49: c = 8'h4E;
            7'd50: c = 8'h4D;
            7'd51: c = 8'h3C;
            7'd52: c = 8'h3E;
            7'd53: c = 8'h3F;
            7'd55: c = 8'h2A;
            7'd57: c = 8'h20;
            7'd74: c = 8'h2D;
            7'd78: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/skf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/skf_front.sv =====
// Front part: accepts beats, tracks prefix/shift/caps and maps scancodes to commands.
`default_nettype none

module skf_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic                     i_action,
    input  wire logic [7:0]               i_scan_byte,
    input  wire logic                     i_cfg_we,
    input  wire skf_pkg::t_cfg_idx        i_cfg_addr,
    input  wire logic [skf_pkg::CHAR_W-1:0] i_cfg_wdata,
    output logic                          o_cmd_push,
    output skf_pkg::t_cmd                 o_cmd
);

    import skf_pkg::*;

    logic              r_prefix, r_shift, r_caps;
    logic              n_prefix, n_shift, n_caps;
    logic [CHAR_W-1:0] r_up, r_down, r_left, r_right;
    logic [6:0]        key;
    logic [CHAR_W-1:0] arrow;
    logic [CHAR_W-1:0] mapped;
    logic [CHAR_W-1:0] ch;

    assign key = i_scan_byte[6:0];

    // Pick the arrow register for a press code, zero for anything else
    always_comb begin
        unique case (key)
            SC_UP:    arrow = r_up;
            SC_DOWN:  arrow = r_down;
            SC_LEFT:  arrow = r_left;
            SC_RIGHT: arrow = r_right;
            default:  arrow = '0;
        endcase
    end

    // Map an unprefixed press, with caps applied only when shift is up
    always_comb begin
        if (r_shift) begin
            mapped = (arrow != '0) ? arrow : upper_map(key);
        end else begin
            mapped = (arrow != '0) ? arrow : plain_map(key);
            if (r_caps && mapped >= CH_LOWER_A && mapped <= CH_LOWER_Z) begin
                mapped = mapped - CH_CASE;
            end
        end
    end

    // Classify the scancode and advance the modifier state
    always_comb begin
        n_prefix = r_prefix;
        n_shift  = r_shift;
        n_caps   = r_caps;
        ch       = '0;
        if (i_accept && !i_action) begin
            priority if (i_scan_byte == SC_PREFIX) begin
                n_prefix = 1'b1;
            end else if ((i_scan_byte & SC_REL_MASK) != '0) begin
                if (key == SC_LSHIFT || key == SC_RSHIFT) begin
                    n_shift = 1'b0;
                end
                n_prefix = 1'b0;
            end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
                n_shift  = 1'b1;
                n_prefix = 1'b0;
            end else if (key == SC_CAPS) begin
                n_caps   = !r_caps;
                n_prefix = 1'b0;
            end else if (r_prefix) begin
                ch       = arrow;
                n_prefix = 1'b0;
            end else begin
                ch = mapped;
            end
        end
    end

    assign o_cmd_push    = i_accept;
    assign o_cmd.is_read = i_action;
    assign o_cmd.ch      = ch;

    // Hold modifier state and arrow registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_up     <= UP_RESET;
            r_down   <= DOWN_RESET;
            r_left   <= LEFT_RESET;
            r_right  <= RIGHT_RESET;
        end else begin
            r_prefix <= n_prefix;
            r_shift  <= n_shift;
            r_caps   <= n_caps;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_UP:    r_up    <= i_cfg_wdata;
                    CFG_DOWN:  r_down  <= i_cfg_wdata;
                    CFG_LEFT:  r_left  <= i_cfg_wdata;
                    CFG_RIGHT: r_right <= i_cfg_wdata;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/skf_cmd_q.sv =====
// Two-entry command queue between the front and back parts.
`default_nettype none

module skf_cmd_q (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire skf_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output skf_pkg::t_cmd       o_cmd
);

    import skf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store command beats
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/skf_back.sv =====
// Back part: character ring FIFO, read stage and result queue.
`default_nettype none

module skf_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_empty,
    input  wire skf_pkg::t_cmd             i_cmd,
    output logic                           o_cmd_pop,
    input  wire logic                      i_res_pop,
    output logic                           o_res_empty,
    output skf_pkg::t_res                  o_res
);

    import skf_pkg::*;

    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [PTR_W-1:0]    wr_inc, rd_inc;
    logic                r_s1_vld, r_s1_pop, r_s1_kw;
    logic                n_s1_pop, n_s1_kw;
    logic                issue;
    logic                ram_we, ram_re;
    logic [CHAR_W-1:0]   ram_rdata;
    t_res                r_oq [OQ_DEPTH];
    t_res                s1_res;
    logic [OQ_PTR_W-1:0] r_oq_wr, r_oq_rd;
    logic [OQ_CNT_W-1:0] r_oq_cnt;
    logic                oq_pop;

    // Issue only with room for this beat and the one in the read stage
    assign issue     = !i_cmd_empty &&
                       ((r_oq_cnt + OQ_CNT_W'(r_s1_vld)) <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign o_cmd_pop = issue;

    assign wr_inc = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
    assign rd_inc = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

    // Push a character or pop one; drop on full or on a zero character, nothing on empty read
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        n_s1_pop = 1'b0;
        if (issue) begin
            if (i_cmd.is_read) begin
                if (r_wr_ptr != r_rd_ptr) begin
                    ram_re   = 1'b1;
                    n_rd_ptr = rd_inc;
                    n_s1_pop = 1'b1;
                end
            end else if (i_cmd.ch != '0 && wr_inc != r_rd_ptr) begin
                ram_we   = 1'b1;
                n_wr_ptr = wr_inc;
            end
        end
        n_s1_kw = (n_wr_ptr != n_rd_ptr);
    end

    skf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_cmd.ch),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // Advance pointers and the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_s1_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_pop <= n_s1_pop;
            r_s1_kw  <= n_s1_kw;
        end
    end

    // Form the result beat once read data is out of the store
    assign s1_res.read_char   = r_s1_pop ? ram_rdata : '0;
    assign s1_res.char_valid  = r_s1_pop;
    assign s1_res.key_waiting = r_s1_kw;

    // Result queue
    assign o_res_empty = (r_oq_cnt == '0);
    assign o_res       = r_oq[r_oq_rd];
    assign oq_pop      = i_res_pop && !o_res_empty;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_oq[r_oq_wr] <= s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s1_vld) begin
                r_oq_wr <= r_oq_wr + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OQ_PTR_W'(1);
            end
            unique case ({r_s1_vld, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(1);
                2'b01:   r_oq_cnt <= r_oq_cnt - OQ_CNT_W'(1);
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scancode_to_ascii_key_fifo.sv =====
// Top level of the set-1 scancode to character decoder with key FIFO.
// Takes one beat per clock on the push side unless full: a scancode byte (action 0) or
// a character read (action 1), and gives exactly one result beat for each, in order,
// on the pop side. Sustained rate is one beat per cycle in both directions without
// stalls; a result passes through the command queue, character store read and result
// queue before it can be popped. The store read port is the single point every read of
// a held character passes through, one per cycle at most. Decoded characters live in a
// 128-entry ring (up to 127 held); a character arriving when the ring is full is
// dropped, and a read from an empty ring returns 0 with char_valid low. Arrow codes
// come from four 8-bit registers (index 0..3: up, down, left, right; reset 128..131),
// to be written only while the block is idle. No clearing pass is needed after reset.
`default_nettype none

module scancode_to_ascii_key_fifo (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       i_action,
    input  wire logic [7:0]                 i_scan_byte,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [skf_pkg::CHAR_W-1:0]      o_read_char,
    output logic                            o_char_valid,
    output logic                            o_key_waiting,
    input  wire logic                       i_cfg_we,
    input  wire skf_pkg::t_cfg_idx          i_cfg_addr,
    input  wire logic [skf_pkg::CHAR_W-1:0] i_cfg_wdata
);

    import skf_pkg::*;

    logic q_push, q_full, q_empty, q_pop;
    t_cmd front_cmd, q_cmd;
    t_res res;

    assign full = q_full;

    skf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !q_full),
        .i_action    (i_action),
        .i_scan_byte (i_scan_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_push  (q_push),
        .o_cmd       (front_cmd)
    );

    skf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    skf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (res)
    );

    assign o_read_char   = res.read_char;
    assign o_char_valid  = res.char_valid;
    assign o_key_waiting = res.key_waiting;

endmodule

`default_nettype wire

// ===== hw/rtl/skf_checker.sv =====
// Port-level checker for the key FIFO, bound to the top level.
`default_nettype none

module skf_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       full,
    input wire logic                       empty,
    input wire logic                       pop,
    input wire logic [skf_pkg::CHAR_W-1:0] o_read_char,
    input wire logic                       o_char_valid,
    input wire logic                       o_key_waiting
);

    // Leave reset with nothing queued and room to take beats
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // A popped character is never zero
    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_char_valid |-> o_read_char != '0)
        else $error("valid read with zero character");

    // No pop means a zero character
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_char_valid |-> o_read_char == '0)
        else $error("character shown without a pop");

    // Hold a stalled result beat
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_read_char) && $stable(o_char_valid)
                           && $stable(o_key_waiting))
        else $error("stalled result beat changed");

endmodule

bind scancode_to_ascii_key_fifo skf_checker u_skf_checker (.*);

`default_nettype wire
